>>> rtl/pid_controller_clamped_integral_assert.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion wrappers shared by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define PID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pid assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pid assertion failed");

`else

`define PID_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/pid_ci_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and reset values of the clamped-integral PID.
// ----------------------------------------------------------------------------
package pid_ci_pkg;

   // Field and datapath widths.
   localparam int MEAS_W      = 12;
   localparam int SETPOINT_W  = 12;
   localparam int GAIN_W      = 16;
   localparam int INTEG_W     = 20;
   localparam int ERR_W       = 13;
   localparam int DIFF_W      = 14;
   localparam int ACC_W       = 21;
   localparam int PROD_P_W    = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W    = GAIN_W + 1 + INTEG_W;
   localparam int PROD_D_W    = GAIN_W + 1 + DIFF_W;
   localparam int SUM_W       = 38;
   localparam int QUOT_W      = SUM_W - 8;
   localparam int ADJSUM_W    = QUOT_W + 1;
   localparam int DRIVE_W     = 24;
   localparam int ADJ_W       = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 48;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SETPOINT      = 3'd0,
      REG_GAIN_P        = 3'd1,
      REG_GAIN_I        = 3'd2,
      REG_GAIN_D        = 3'd3,
      REG_INTEGRAL_HIGH = 3'd4,
      REG_INTEGRAL_LOW  = 3'd5
   } csr_index_type;

   // Register reset values.
   localparam logic [SETPOINT_W-1:0]     SETPOINT_RESET      = 12'd1000;
   localparam logic [GAIN_W-1:0]         GAIN_P_RESET        = 16'd230;
   localparam logic [GAIN_W-1:0]         GAIN_I_RESET        = 16'd13;
   localparam logic [GAIN_W-1:0]         GAIN_D_RESET        = 16'd13;
   localparam logic signed [INTEG_W-1:0] INTEGRAL_HIGH_RESET = 20'sd200;
   localparam logic signed [INTEG_W-1:0] INTEGRAL_LOW_RESET  = -20'sd200;

   // Saturation limits: drive limits at the width of the Q.8 sum, adjusted-value limits at ADJSUM_W.
   localparam logic signed [SUM_W-1:0]    DRIVE_MAX = 38'sd8388607;
   localparam logic signed [SUM_W-1:0]    DRIVE_MIN = -38'sd8388608;
   localparam logic signed [ADJSUM_W-1:0] ADJ_MAX   = 31'sd65535;
   localparam logic signed [ADJSUM_W-1:0] ADJ_MIN   = -31'sd65536;

   // Bias that turns an arithmetic shift into truncation toward zero.
   localparam logic signed [SUM_W-1:0] TRUNC_BIAS = 38'sd255;

endpackage

>>> rtl/pid_controller_clamped_integral.sv
// ----------------------------------------------------------------------------
// PID controller with clamped integral
// Three-stage PID datapath: error and integral update, gain products, saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Each measurement transaction on the req_ stream yields exactly one result
//   transaction on the rsp_ stream carrying the saturated Q15.8 drive and the
//   adjusted value (measurement plus the unsaturated sum truncated toward zero, then saturated).
//   Gains, setpoint and integral bounds are written on the csr_ channel, which
//   is always ready; write it only while no transaction is in flight.
//   The error and clamped integral are registered at the acceptance edge,
//   the three gain products and their sum in stage 2, and the saturated
//   result in the output register; a receiver stall can hold any stage.
//   Throughput is one transaction per cycle while the receiver takes results;
//   the integral and previous error are updated at the acceptance edge, so
//   the next sample may follow at once.
//   When the receiver stalls, the result holds and the pipeline keeps
//   accepting until all three stages are full; req_tready then drops.
//   Synchronous reset empties the pipeline, clears the integral and the
//   previous error, and loads the register reset values.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_integral_assert.svh"

module pid_controller_clamped_integral (
   input  logic                                  clock,
   input  logic                                  reset,
   // Measurement stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [pid_ci_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [11:0] measurement
   // Result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pid_ci_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [23:0] drive, [40:24] adjusted_value
   // Configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pid_ci_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pid_ci_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [pid_ci_pkg::SETPOINT_W-1:0]     setpoint_ff;
   logic [pid_ci_pkg::GAIN_W-1:0]         gain_p_ff;
   logic [pid_ci_pkg::GAIN_W-1:0]         gain_i_ff;
   logic [pid_ci_pkg::GAIN_W-1:0]         gain_d_ff;
   logic signed [pid_ci_pkg::INTEG_W-1:0] integral_high_ff;
   logic signed [pid_ci_pkg::INTEG_W-1:0] integral_low_ff;

   // Controller state.
   logic signed [pid_ci_pkg::INTEG_W-1:0] integral_sum_ff;
   logic signed [pid_ci_pkg::INTEG_W-1:0] integral_sum_in;
   logic signed [pid_ci_pkg::ERR_W-1:0]   prev_err_ff;

   // Stage 1: error, clamped integral and error difference.
   logic                                  s1_valid_ff;
   logic signed [pid_ci_pkg::ERR_W-1:0]   s1_err_ff;
   logic signed [pid_ci_pkg::INTEG_W-1:0] s1_integ_ff;
   logic signed [pid_ci_pkg::DIFF_W-1:0]  s1_diff_ff;
   logic [pid_ci_pkg::MEAS_W-1:0]         s1_meas_ff;

   // Stage 2: Q.8 sum of the three products.
   logic                                  s2_valid_ff;
   logic signed [pid_ci_pkg::SUM_W-1:0]   s2_sum_ff;
   logic signed [pid_ci_pkg::SUM_W-1:0]   s2_sum_in;
   logic [pid_ci_pkg::MEAS_W-1:0]         s2_meas_ff;

   // Output register.
   logic                                  out_valid_ff;
   logic signed [pid_ci_pkg::DRIVE_W-1:0] out_drive_ff;
   logic signed [pid_ci_pkg::DRIVE_W-1:0] out_drive_in;
   logic signed [pid_ci_pkg::ADJ_W-1:0]   out_adj_ff;
   logic signed [pid_ci_pkg::ADJ_W-1:0]   out_adj_in;

   // Pipeline control.
   logic                                  req_accept;
   logic                                  csr_accept;
   logic                                  out_ready;
   logic                                  s2_ready;

   // Stage 1 combinational terms.
   logic [pid_ci_pkg::MEAS_W-1:0]         meas_w;
   logic signed [pid_ci_pkg::ERR_W-1:0]   err_w;
   logic signed [pid_ci_pkg::ACC_W-1:0]   acc_w;
   logic signed [pid_ci_pkg::DIFF_W-1:0]  diff_w;

   // Stage 2 products.
   logic signed [pid_ci_pkg::PROD_P_W-1:0] prod_p_w;
   logic signed [pid_ci_pkg::PROD_I_W-1:0] prod_i_w;
   logic signed [pid_ci_pkg::PROD_D_W-1:0] prod_d_w;

   // Output stage terms.
   logic signed [pid_ci_pkg::SUM_W-1:0]    biased_w;
   logic signed [pid_ci_pkg::QUOT_W-1:0]   quot_w;
   logic signed [pid_ci_pkg::ADJSUM_W-1:0] adj_sum_w;

   // Handshakes: each stage moves when the one after it can take its item.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // Configuration register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff      <= pid_ci_pkg::SETPOINT_RESET;
         gain_p_ff        <= pid_ci_pkg::GAIN_P_RESET;
         gain_i_ff        <= pid_ci_pkg::GAIN_I_RESET;
         gain_d_ff        <= pid_ci_pkg::GAIN_D_RESET;
         integral_high_ff <= pid_ci_pkg::INTEGRAL_HIGH_RESET;
         integral_low_ff  <= pid_ci_pkg::INTEGRAL_LOW_RESET;
      end else if (csr_accept) begin
         unique case (csr_index)
            pid_ci_pkg::REG_SETPOINT:      setpoint_ff      <= csr_wdata[pid_ci_pkg::SETPOINT_W-1:0];
            pid_ci_pkg::REG_GAIN_P:        gain_p_ff        <= csr_wdata[pid_ci_pkg::GAIN_W-1:0];
            pid_ci_pkg::REG_GAIN_I:        gain_i_ff        <= csr_wdata[pid_ci_pkg::GAIN_W-1:0];
            pid_ci_pkg::REG_GAIN_D:        gain_d_ff        <= csr_wdata[pid_ci_pkg::GAIN_W-1:0];
            pid_ci_pkg::REG_INTEGRAL_HIGH: integral_high_ff <= $signed(csr_wdata);
            pid_ci_pkg::REG_INTEGRAL_LOW:  integral_low_ff  <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Error, running integral and derivative difference of the incoming sample.
   always_comb begin
      meas_w = req_tdata[pid_ci_pkg::MEAS_W-1:0];
      err_w  = $signed({1'b0, setpoint_ff}) - $signed({1'b0, meas_w});
      acc_w  = pid_ci_pkg::ACC_W'(integral_sum_ff) + pid_ci_pkg::ACC_W'(err_w);
      diff_w = pid_ci_pkg::DIFF_W'(err_w) - pid_ci_pkg::DIFF_W'(prev_err_ff);
      // The upper bound is checked first; it wins where both bounds apply.
      if (acc_w > pid_ci_pkg::ACC_W'(integral_high_ff)) begin
         integral_sum_in = integral_high_ff;
      end else if (acc_w < pid_ci_pkg::ACC_W'(integral_low_ff)) begin
         integral_sum_in = integral_low_ff;
      end else begin
         integral_sum_in = acc_w[pid_ci_pkg::INTEG_W-1:0];
      end
   end

   // Controller state and stage 1 registers, updated on each accepted sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_sum_ff <= '0;
         prev_err_ff     <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            integral_sum_ff <= integral_sum_in;
            prev_err_ff     <= err_w;
            s1_valid_ff     <= 1'b1;
         end else if (s2_ready) begin
            s1_valid_ff     <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff   <= err_w;
         s1_integ_ff <= integral_sum_in;
         s1_diff_ff  <= diff_w;
         s1_meas_ff  <= meas_w;
      end
   end

   // Gain products and their Q.8 sum.
   always_comb begin
      prod_p_w  = $signed({1'b0, gain_p_ff}) * s1_err_ff;
      prod_i_w  = $signed({1'b0, gain_i_ff}) * s1_integ_ff;
      prod_d_w  = $signed({1'b0, gain_d_ff}) * s1_diff_ff;
      s2_sum_in = pid_ci_pkg::SUM_W'(prod_p_w) + pid_ci_pkg::SUM_W'(prod_i_w)
                + pid_ci_pkg::SUM_W'(prod_d_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_sum_ff  <= s2_sum_in;
         s2_meas_ff <= s1_meas_ff;
      end
   end

   // Drive saturation and the adjusted value from the unsaturated sum.
   always_comb begin
      if (s2_sum_ff > pid_ci_pkg::DRIVE_MAX) begin
         out_drive_in = pid_ci_pkg::DRIVE_MAX[pid_ci_pkg::DRIVE_W-1:0];
      end else if (s2_sum_ff < pid_ci_pkg::DRIVE_MIN) begin
         out_drive_in = pid_ci_pkg::DRIVE_MIN[pid_ci_pkg::DRIVE_W-1:0];
      end else begin
         out_drive_in = s2_sum_ff[pid_ci_pkg::DRIVE_W-1:0];
      end
      // Negative sums get a bias so the shift truncates toward zero.
      biased_w  = s2_sum_ff + (s2_sum_ff[pid_ci_pkg::SUM_W-1] ? pid_ci_pkg::TRUNC_BIAS
                                                               : '0);
      quot_w    = biased_w[pid_ci_pkg::SUM_W-1:8];
      adj_sum_w = pid_ci_pkg::ADJSUM_W'(quot_w)
                + pid_ci_pkg::ADJSUM_W'($signed({1'b0, s2_meas_ff}));
      if (adj_sum_w > pid_ci_pkg::ADJ_MAX) begin
         out_adj_in = pid_ci_pkg::ADJ_MAX[pid_ci_pkg::ADJ_W-1:0];
      end else if (adj_sum_w < pid_ci_pkg::ADJ_MIN) begin
         out_adj_in = pid_ci_pkg::ADJ_MIN[pid_ci_pkg::ADJ_W-1:0];
      end else begin
         out_adj_in = adj_sum_w[pid_ci_pkg::ADJ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         out_drive_ff <= out_drive_in;
         out_adj_ff   <= out_adj_in;
      end
   end

   // Result transaction.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(pid_ci_pkg::RSP_TDATA_W - pid_ci_pkg::DRIVE_W
                          - pid_ci_pkg::ADJ_W){1'b0}}, out_adj_ff, out_drive_ff};

   // The integral stays inside ordered bounds after every accepted sample.
   `PID_ASSERT_NEXT(a_integral_in_bounds, clock, reset,
      req_accept && (integral_low_ff <= integral_high_ff),
      (integral_sum_ff <= $past(integral_high_ff)) && (integral_sum_ff >= $past(integral_low_ff)))

   // Without an accepted sample the controller state does not move.
   `PID_ASSERT_NEXT(a_state_holds, clock, reset,
      !req_accept,
      $stable(integral_sum_ff) && $stable(prev_err_ff))

   // An item in stage 2 that cannot advance is kept, not dropped.
   `PID_ASSERT_NEXT(a_s2_kept, clock, reset,
      s2_valid_ff && !out_ready,
      s2_valid_ff && $stable(s2_sum_ff))

   // An accepted sample always lands in stage 1.
   `PID_ASSERT_NEXT(a_s1_loaded, clock, reset,
      req_accept,
      s1_valid_ff && (s1_err_ff == $past(err_w)))

endmodule
